// File: design/pre_alignment_edit_filter_core_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef PRE_ALIGNMENT_EDIT_FILTER_CORE_MACROS_SVH
`define PRE_ALIGNMENT_EDIT_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pafe_pkg.sv
`default_nettype none

package pafe_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_POS,
    ST_CHECK,
    ST_CMP,
    ST_END
  } state_t;

  typedef struct packed {
    logic [7:0] q;
    logic [7:0] r;
  } char_pair_t;

  localparam int unsigned MAX_EDITS_W = 5;
  localparam int unsigned EDIT_W      = 9;
  localparam logic [MAX_EDITS_W-1:0] MAX_EDITS_RESET = 5'd3;

endpackage

`default_nettype wire

// File: design/pafe_store.sv
`default_nettype none

module pafe_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire pafe_pkg::char_pair_t wr_data,
  input  wire logic [AW-1:0]        rd_q_addr,
  input  wire logic [AW-1:0]        rd_r_addr,
  output pafe_pkg::char_pair_t      rd_data
);

  logic [7:0] q_mem [DEPTH];
  logic [7:0] r_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_addr] <= wr_data.q;
      r_mem[wr_addr] <= wr_data.r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data.q <= q_mem[rd_q_addr];
    rd_data.r <= r_mem[rd_r_addr];
  end

endmodule

`default_nettype wire

// File: design/pre_alignment_edit_filter_core.sv
`default_nettype none
// Pre-alignment edit filter. A read is loaded as query/reference character
// pairs, one transaction per cycle on start while busy is low, into two
// character memories. The transaction with in_last high ends the read and
// starts the greedy diagonal walk; busy stays high until the estimate is out.
// Pairs beyond READ_LEN are dropped, but their last flag still starts the walk.
// The result appears on out_edit_estimate for exactly one cycle with out_valid
// high, in the cycle after the walk ends; the receiver cannot stall it.
// The walk uses one read port per memory. Each matching character goes through
// ST_CHECK (address), then ST_CMP (compare of the registered data). A diagonal
// ends in ST_END, reached from ST_CHECK when it runs off the read and from ST_CMP
// on a mismatch. Each checkpoint starts in ST_POS and walks 2 * min(max_edits,
// MAX_SHIFT) + 1 diagonals in turn; ST_POS also gives the result once the walk
// has passed the end of the read.
// max_edits is written through cfg_valid/cfg_ready, accepted only while idle.
// Reset returns the block to loading with an empty read and max_edits = 3;
// the memories are not cleared and need no clearing pass.
module pre_alignment_edit_filter_core #(
  parameter int READ_LEN  = 256,
  parameter int MAX_SHIFT = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [7:0]                             in_query_char,
  input  wire logic [7:0]                             in_ref_char,
  input  wire logic                                   in_last,
  output logic                                        out_valid,
  output logic [pafe_pkg::EDIT_W-1:0]                 out_edit_estimate,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pafe_pkg::MAX_EDITS_W-1:0]       cfg_max_edits
);

  `include "pre_alignment_edit_filter_core_macros.svh"

  localparam int AW = (READ_LEN > 1) ? $clog2(READ_LEN) : 1;
  localparam int CW = $clog2(READ_LEN + 1);
  localparam int SW = $clog2(MAX_SHIFT + 2);
  localparam int XW = ((CW > SW) ? CW : SW) + 1;
  localparam int EW = pafe_pkg::EDIT_W;

  pafe_pkg::state_t state_r, state_nxt;

  logic [pafe_pkg::MAX_EDITS_W-1:0] max_edits_r;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [SW-1:0] shift_r, shift_nxt;
  logic          dir_r, dir_nxt;
  logic [EW-1:0] edit_r, edit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [EW-1:0] out_edit_r, out_edit_nxt;

  logic                  accept;
  logic                  wr_en;
  pafe_pkg::char_pair_t  wr_data;
  pafe_pkg::char_pair_t  rd_data;
  logic [SW-1:0]         lim;
  logic [XW-1:0]         n_x, s_x, qi_x;
  logic                  diag_ok;
  logic [CW-1:0]         best_sel;
  logic [CW:0]           pos_sum;
  logic                  last_diag;

  assign busy      = (state_r != pafe_pkg::ST_LOAD);
  assign cfg_ready = (state_r == pafe_pkg::ST_LOAD);
  assign accept    = start && !busy;
  assign wr_en     = accept && (load_cnt_r < CW'(READ_LEN));
  assign wr_data.q = in_query_char;
  assign wr_data.r = in_ref_char;

  assign out_valid         = out_valid_r;
  assign out_edit_estimate = out_edit_r;

  assign lim = (32'(max_edits_r) > 32'(MAX_SHIFT)) ? SW'(MAX_SHIFT) : SW'(max_edits_r);

  assign n_x     = XW'(n_r);
  assign s_x     = XW'(shift_r);
  assign qi_x    = dir_r ? (n_x + s_x) : (n_x - s_x);
  assign diag_ok = (n_r < len_r) && (dir_r || (n_x >= s_x)) && (qi_x < XW'(len_r));

  assign best_sel  = (run_r > best_r) ? run_r : best_r;
  assign pos_sum   = (CW + 1)'(pos_r) + (CW + 1)'(best_sel);
  assign last_diag = (shift_r == lim) && (dir_r || (shift_r == '0));

  pafe_store #(
    .DEPTH (READ_LEN),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (load_cnt_r[AW-1:0]),
    .wr_data   (wr_data),
    .rd_q_addr (qi_x[AW-1:0]),
    .rd_r_addr (n_r[AW-1:0]),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pafe_pkg::ST_LOAD;
      max_edits_r <= pafe_pkg::MAX_EDITS_RESET;
      load_cnt_r  <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      edit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      edit_r      <= edit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_edits_r <= cfg_max_edits;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    run_r      <= run_nxt;
    best_r     <= best_nxt;
    shift_r    <= shift_nxt;
    dir_r      <= dir_nxt;
    out_edit_r <= out_edit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    edit_nxt      = edit_r;
    n_nxt         = n_r;
    run_nxt       = run_r;
    best_nxt      = best_r;
    shift_nxt     = shift_r;
    dir_nxt       = dir_r;
    out_valid_nxt = 1'b0;
    out_edit_nxt  = out_edit_r;
    unique case (state_r)
      pafe_pkg::ST_LOAD: begin
        if (accept) begin
          if (wr_en) begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
          if (in_last) begin
            len_nxt      = wr_en ? (load_cnt_r + 1'b1) : load_cnt_r;
            load_cnt_nxt = '0;
            pos_nxt      = '0;
            edit_nxt     = '0;
            state_nxt    = pafe_pkg::ST_POS;
          end
        end
      end
      pafe_pkg::ST_POS: begin
        if (pos_r >= len_r) begin
          out_valid_nxt = 1'b1;
          out_edit_nxt  = edit_r;
          state_nxt     = pafe_pkg::ST_LOAD;
        end else begin
          shift_nxt = '0;
          dir_nxt   = 1'b0;
          n_nxt     = pos_r;
          run_nxt   = '0;
          best_nxt  = '0;
          state_nxt = pafe_pkg::ST_CHECK;
        end
      end
      pafe_pkg::ST_CHECK: begin
        state_nxt = diag_ok ? pafe_pkg::ST_CMP : pafe_pkg::ST_END;
      end
      pafe_pkg::ST_CMP: begin
        if (rd_data.q == rd_data.r) begin
          run_nxt   = run_r + 1'b1;
          n_nxt     = n_r + 1'b1;
          state_nxt = pafe_pkg::ST_CHECK;
        end else begin
          state_nxt = pafe_pkg::ST_END;
        end
      end
      pafe_pkg::ST_END: begin
        best_nxt = best_sel;
        if (last_diag) begin
          if (pos_sum < (CW + 1)'(len_r)) begin
            edit_nxt = edit_r + 1'b1;
            pos_nxt  = CW'(pos_sum + 1'b1);
          end else begin
            pos_nxt  = CW'(pos_sum);
          end
          state_nxt = pafe_pkg::ST_POS;
        end else begin
          if ((shift_r == '0) || dir_r) begin
            shift_nxt = shift_r + 1'b1;
            dir_nxt   = 1'b0;
          end else begin
            dir_nxt   = 1'b1;
          end
          n_nxt     = pos_r;
          run_nxt   = '0;
          state_nxt = pafe_pkg::ST_CHECK;
        end
      end
      default: begin
        state_nxt = pafe_pkg::ST_LOAD;
      end
    endcase
  end

  `PAFE_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid_r, !busy, "result strobe while busy")
  `PAFE_ASSERT_SAME(a_cmp_after_check, clk, rst_n, state_r == pafe_pkg::ST_CMP, $past(state_r) == pafe_pkg::ST_CHECK, "compare without a read issued")
  `PAFE_ASSERT_SAME(a_pos_in_range, clk, rst_n, busy, pos_r <= len_r, "walk position beyond read length")
  `PAFE_ASSERT_NEXT(a_last_starts_walk, clk, rst_n, accept && in_last, busy && (load_cnt_r == '0), "last transaction did not start the walk")

endmodule

`default_nettype wire

// File: tb/sv/tb_pre_alignment_edit_filter_core.sv
`default_nettype none

module tb_pre_alignment_edit_filter_core;

  localparam int unsigned READ_LEN    = 256;
  localparam int unsigned MAX_SHIFT   = 16;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE      = 20;

  typedef enum {STYLE_NOISE, STYLE_EDITED, STYLE_MATCH} read_style_t;
  typedef enum {ALPHA_BYTE, ALPHA_BASES, ALPHA_RAILS} alphabet_t;

  typedef struct {
    logic [7:0] query;
    logic [7:0] refc;
    logic       last;
  } char_pair_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_query_char = '0;
  logic [7:0] in_ref_char = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic [pafe_pkg::EDIT_W-1:0] out_edit_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pafe_pkg::MAX_EDITS_W-1:0] cfg_max_edits = '0;

  char_pair_s pending_pairs[$];
  logic [pafe_pkg::EDIT_W-1:0] expected_edits[$];

  logic [7:0] read_query[READ_LEN];
  logic [7:0] read_ref[READ_LEN];
  int unsigned read_fill = 0;
  int unsigned edit_limit = pafe_pkg::MAX_EDITS_RESET;

  int unsigned burst_left = 8;
  int unsigned idle_gap = 0;
  bit steady_flow = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned edit_settings[8] = '{0, 16, 31, 1, 17, 0, 2, 8};

  pre_alignment_edit_filter_core #(
    .READ_LEN(READ_LEN),
    .MAX_SHIFT(MAX_SHIFT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_query_char(in_query_char),
    .in_ref_char(in_ref_char),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_edit_estimate(out_edit_estimate),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_max_edits(cfg_max_edits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned diag_run(int unsigned pos, int unsigned len,
                                           int unsigned up, int unsigned down);
    int unsigned run;
    int unsigned n;
    int unsigned qi;
    run = 0;
    for (n = pos; n < len; n++) begin
      if (n < up) break;
      qi = n - up + down;
      if (qi >= len) break;
      if (read_query[qi] != read_ref[n]) break;
      run++;
    end
    return run;
  endfunction

  function automatic logic [pafe_pkg::EDIT_W-1:0] walk_edits(int unsigned len);
    int unsigned shifts;
    int unsigned pos;
    int unsigned edits;
    int unsigned best;
    int unsigned run;
    int unsigned r;
    shifts = (edit_limit > MAX_SHIFT) ? MAX_SHIFT : edit_limit;
    pos = 0;
    edits = 0;
    while (pos < len) begin
      best = diag_run(pos, len, 0, 0);
      if (best == len) break;
      for (r = 1; r <= shifts; r++) begin
        run = diag_run(pos, len, r, 0);
        if (run > best) best = run;
        run = diag_run(pos, len, 0, r);
        if (run > best) best = run;
      end
      pos += best;
      if (pos < len) begin
        edits++;
        pos++;
      end
    end
    return edits[pafe_pkg::EDIT_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("MISMATCH at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    mismatches++;
  endtask

  function automatic logic [7:0] pick_char(alphabet_t alpha);
    logic [7:0] c;
    case (alpha)
      ALPHA_BYTE: c = 8'($urandom_range(255));
      ALPHA_BASES: begin
        case ($urandom_range(3))
          0: c = "A";
          1: c = "C";
          2: c = "G";
          default: c = "T";
        endcase
      end
      default: c = $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
    return c;
  endfunction

  task automatic push_pair(logic [7:0] q, logic [7:0] r, logic last);
    char_pair_s p;
    p.query = q;
    p.refc = r;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  task automatic queue_read(int unsigned len, read_style_t style);
    logic [7:0] ref_seq[$];
    logic [7:0] qry_seq[$];
    int unsigned i;
    int unsigned pct;
    int unsigned edit_pct;
    alphabet_t alpha;
    pct = $urandom_range(9);
    alpha = (pct < 6) ? ALPHA_BASES : ((pct < 9) ? ALPHA_BYTE : ALPHA_RAILS);
    for (i = 0; i < len; i++) ref_seq.push_back(pick_char(alpha));
    case (style)
      STYLE_MATCH: qry_seq = ref_seq;
      STYLE_NOISE: begin
        for (i = 0; i < len; i++) qry_seq.push_back(pick_char(alpha));
      end
      default: begin
        i = 0;
        edit_pct = $urandom_range(8);
        while (qry_seq.size() < len) begin
          pct = $urandom_range(99);
          if (i >= len) begin
            qry_seq.push_back(pick_char(alpha));
          end else if (pct < edit_pct) begin
            qry_seq.push_back(pick_char(alpha));
            i++;
          end else if (pct < 2 * edit_pct) begin
            qry_seq.push_back(pick_char(alpha));
          end else if (pct < 3 * edit_pct) begin
            i++;
          end else begin
            qry_seq.push_back(ref_seq[i]);
            i++;
          end
        end
      end
    endcase
    for (i = 0; i < len; i++) push_pair(qry_seq[i], ref_seq[i], i == len - 1);
  endtask

  task automatic fill_phase(int unsigned items);
    int unsigned count;
    int unsigned len;
    int unsigned pick;
    read_style_t style;
    count = 0;
    while (count < items) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 16);
      else if (pick < 92) len = $urandom_range(17, 64);
      else if (pick < 98) len = $urandom_range(65, 255);
      else len = READ_LEN;
      pick = $urandom_range(99);
      style = (pick < 60) ? STYLE_EDITED : ((pick < 75) ? STYLE_MATCH : STYLE_NOISE);
      queue_read(len, style);
      count += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || expected_edits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_edit_limit(int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_max_edits <= value[pafe_pkg::MAX_EDITS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    edit_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (idle_gap > 0) begin
      idle_gap--;
      start <= 1'b0;
    end else if (pending_pairs.size() > 0) begin
      start <= 1'b1;
      in_query_char <= pending_pairs[0].query;
      in_ref_char <= pending_pairs[0].refc;
      in_last <= pending_pairs[0].last;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      void'(pending_pairs.pop_front());
      if (read_fill < READ_LEN) begin
        read_query[read_fill] = in_query_char;
        read_ref[read_fill] = in_ref_char;
        read_fill++;
      end
      if (in_last) begin
        expected_edits.push_back(walk_edits(read_fill));
        read_fill = 0;
      end
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (steady_flow) idle_gap = 0;
        else if ($urandom_range(9) == 0) idle_gap = $urandom_range(20, 60);
        else idle_gap = $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pre_alignment_edit_filter_core verification failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_edits.size() == 0) begin
        report_mismatch("unexpected edit_estimate", 0, out_edit_estimate);
      end else begin
        if (out_edit_estimate != expected_edits[0]) begin
          report_mismatch("edit_estimate", expected_edits[0], out_edit_estimate);
        end
        void'(expected_edits.pop_front());
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned i;
    edit_settings[5] = $urandom_range(31);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-pair reads leave the lower diagonals running off the end of the query.
    push_pair(8'h00, 8'h00, 1'b1);
    push_pair(8'hFF, 8'h00, 1'b1);
    for (i = 0; i < 4; i++) push_pair(8'hFF, 8'hFF, i == 3);
    push_pair("C", "A", 1'b0);
    push_pair("G", "C", 1'b0);
    push_pair("T", "G", 1'b0);
    push_pair("A", "T", 1'b0);
    push_pair("C", "A", 1'b1);
    for (i = 0; i < 6; i++) push_pair(8'hAA, 8'h55, i == 5);
    push_pair(8'h7F, 8'h7F, 1'b0);
    push_pair(8'h80, 8'h01, 1'b0);
    push_pair(8'h7F, 8'h7F, 1'b1);
    wait_drained();

    for (k = 0; k < 8; k++) begin
      write_edit_limit(edit_settings[k]);
      steady_flow = (k % 3 == 2);
      fill_phase(60);
      if (k == 2) begin
        // Pairs past the store depth are dropped, and the last one still starts the walk.
        queue_read($urandom_range(READ_LEN + 1, READ_LEN + 44), STYLE_EDITED);
        queue_read(READ_LEN, STYLE_EDITED);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("pre_alignment_edit_filter_core verification clean");
    end else begin
      $display("pre_alignment_edit_filter_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
